[rtl/psu_pkg.sv]
package psu_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int PIX_W      = CHAN_W * NUM_CHAN;
    localparam int CODE_W     = 3;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register select is the word address bit of paddr
    localparam int   REG_SEL_BIT    = 2;
    localparam logic REG_SEL_WIDTH  = 1'b0;
    localparam logic REG_SEL_HEIGHT = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    localparam int PAETH_W = CHAN_W + 3;

    typedef logic [PAETH_W-1:0] t_paeth_mag;

    // absolute value of a signed paeth distance
    function automatic t_paeth_mag paeth_abs(input logic signed [PAETH_W-1:0] s);
        logic signed [PAETH_W-1:0] neg;
        neg = -s;
        return s[PAETH_W-1] ? t_paeth_mag'(neg) : t_paeth_mag'(s);
    endfunction

    // nearest of a, b, c to a+b-c, ties resolved a then b then c
    function automatic logic [CHAN_W-1:0] paeth_pick(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] c
    );
        logic signed [PAETH_W-1:0] sa;
        logic signed [PAETH_W-1:0] sb;
        logic signed [PAETH_W-1:0] sc;
        t_paeth_mag pa;
        t_paeth_mag pb;
        t_paeth_mag pc;
        logic [CHAN_W-1:0] pick;
        sa = $signed({3'b000, a});
        sb = $signed({3'b000, b});
        sc = $signed({3'b000, c});
        pa = paeth_abs(sb - sc);
        pb = paeth_abs(sa - sc);
        pc = paeth_abs(sa + sb - sc - sc);
        if (pa <= pb && pa <= pc) begin
            pick = a;
        end else if (pb <= pc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

    // rebuild one pixel from its filtered value and the three neighbours
    function automatic logic [PIX_W-1:0] unfilter_pixel(
        input logic [CODE_W-1:0] code,
        input logic [PIX_W-1:0]  filt,
        input logic [PIX_W-1:0]  left,
        input logic [PIX_W-1:0]  above,
        input logic [PIX_W-1:0]  diag
    );
        logic [CHAN_W-1:0] x;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] c;
        logic [CHAN_W-1:0] pred;
        logic [CHAN_W:0]   sum_ab;
        logic [PIX_W-1:0]  res;
        res = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            x      = filt[k*CHAN_W +: CHAN_W];
            a      = left[k*CHAN_W +: CHAN_W];
            b      = above[k*CHAN_W +: CHAN_W];
            c      = diag[k*CHAN_W +: CHAN_W];
            sum_ab = {1'b0, a} + {1'b0, b};
            case (code)
                FILT_SUB:   pred = a;
                FILT_UP:    pred = b;
                FILT_AVG:   pred = sum_ab[CHAN_W:1];
                FILT_PAETH: pred = paeth_pick(a, b, c);
                default:    pred = '0;
            endcase
            res[k*CHAN_W +: CHAN_W] = x + pred;
        end
        return res;
    endfunction

endpackage

[rtl/psu_if.sv]
interface psu_in_if;
    import psu_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   filtered_red;
    logic [CHAN_W-1:0]   filtered_green;
    logic [CHAN_W-1:0]   filtered_blue;
    logic [CHAN_W-1:0]   filtered_alpha;
    logic [CODE_W-1:0]   filter_code;

    modport source (
        output valid, filtered_red, filtered_green, filtered_blue, filtered_alpha,
               filter_code,
        input  ready
    );
    modport sink (
        input  valid, filtered_red, filtered_green, filtered_blue, filtered_alpha,
               filter_code,
        output ready
    );
endinterface

interface psu_out_if;
    import psu_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              bad_filter;
    logic              row_end;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, bad_filter, row_end,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, bad_filter, row_end,
        output ready
    );
endinterface

[rtl/psu_line_store.sv]
module psu_line_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [psu_pkg::PIX_W-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [psu_pkg::PIX_W-1:0]  o_rd_data
);
    import psu_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic [PIX_W-1:0] r_fwd_data;
    logic             r_fwd_hit;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // bypass when the same entry is written and read at one edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

[rtl/png_scanline_unfilter.sv]
// PNG scanline unfilter for a raster stream of 8-bit RGBA pixels.
// i_pix takes one filtered pixel per transaction together with the row's
// filter code (none, sub, up, average, paeth); o_pix returns one rebuilt
// pixel per input, in order, with bad_filter set for codes 5 to 7 (pixel
// passed unchanged) and row_end set on the last pixel of each row.
// image_width (byte address 0) and image_height (byte address 4) are to
// be written over the APB port while the stream is idle; the block does
// not enforce this. Writes leave the column and row counters where they
// are. A result is registered and shows on o_pix in the cycle after its
// input transaction. Throughput: one pixel per clock while o_pix is not
// stalled. The loop from the rebuilt left pixel through the predictor
// back into the left-pixel register is combinational; the line store is
// read one column ahead so the pixel above is ready for the next input.
// Reset: counters go to zero, width and height to 1; the line store is not
// cleared, since each entry is written in one row before the next row
// reads it.
// Stall: the result waits in the output register; i_pix.ready stays high
// as long as that register is empty or being taken in the same cycle.
module png_scanline_unfilter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    psu_in_if.sink                            i_pix,
    psu_out_if.source                         o_pix,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [psu_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [psu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [psu_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import psu_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [HEIGHT_W-1:0] n_row;
    logic [PIX_W-1:0]    r_left;
    logic [PIX_W-1:0]    r_diag;
    logic [PIX_W-1:0]    r_out_pix;
    logic                r_out_valid;
    logic                r_out_bad;
    logic                r_out_row_end;

    logic                cfg_wr;
    logic                reg_sel;
    logic                accept;
    logic                has_left;
    logic                has_up;
    logic [CMP_W-1:0]    width_ext;
    logic [CMP_W-1:0]    width_eff;
    logic [HEIGHT_W:0]   height_eff;
    logic                row_end;
    logic                row_wrap;
    logic [PIX_W-1:0]    store_q;
    logic [PIX_W-1:0]    filt_pix;
    logic [PIX_W-1:0]    left_pix;
    logic [PIX_W-1:0]    above_pix;
    logic [PIX_W-1:0]    diag_pix;
    logic [PIX_W-1:0]    result;
    logic                bad_code;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[REG_SEL_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(1);
            r_height <= HEIGHT_W'(1);
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_SEL_WIDTH:  r_width  <= pwdata[WIDTH_W-1:0];
                REG_SEL_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SEL_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_SEL_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:        prdata = '0;
        endcase
    end

    // handshake: output register frees the input side
    assign i_pix.ready = !r_out_valid || o_pix.ready;
    assign accept      = i_pix.valid && i_pix.ready;

    // effective geometry
    assign width_ext  = CMP_W'(r_width);
    assign width_eff  = (width_ext == '0) ? CMP_W'(1) :
                        (width_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_ext;
    assign height_eff = (r_height == '0) ? (HEIGHT_W+1)'(1) : {1'b0, r_height};
    assign row_end    = (CMP_W'(r_col) + CMP_W'(1)) >= width_eff;
    assign row_wrap   = ({1'b0, r_row} + (HEIGHT_W+1)'(1)) >= height_eff;

    // raster counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_row + HEIGHT_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // previous row, read one column ahead
    psu_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (result),
        .i_rd_addr (n_col),
        .o_rd_data (store_q)
    );

    // neighbours, zero outside the image
    assign has_left  = (r_col != '0);
    assign has_up    = (r_row != '0);
    assign left_pix  = has_left ? r_left : '0;
    assign above_pix = has_up ? store_q : '0;
    assign diag_pix  = (has_left && has_up) ? r_diag : '0;
    assign filt_pix  = {i_pix.filtered_alpha, i_pix.filtered_blue,
                        i_pix.filtered_green, i_pix.filtered_red};
    assign bad_code  = i_pix.filter_code > CODE_W'(FILT_PAETH);
    assign result    = unfilter_pixel(i_pix.filter_code, filt_pix, left_pix,
                                      above_pix, diag_pix);

    // state update on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_diag <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_left <= result;
                r_diag <= above_pix;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
        if (accept) begin
            r_out_pix     <= result;
            r_out_bad     <= bad_code;
            r_out_row_end <= row_end;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.out_red    = r_out_pix[0*CHAN_W +: CHAN_W];
    assign o_pix.out_green  = r_out_pix[1*CHAN_W +: CHAN_W];
    assign o_pix.out_blue   = r_out_pix[2*CHAN_W +: CHAN_W];
    assign o_pix.out_alpha  = r_out_pix[3*CHAN_W +: CHAN_W];
    assign o_pix.bad_filter = r_out_bad;
    assign o_pix.row_end    = r_out_row_end;

`ifndef SYNTHESIS
    // a row end returns the column counter to zero
    a_row_end_clears_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && row_end |=> r_col == '0)
        else $error("column counter not cleared after row end");

    // inside a row the column counter steps by one
    a_col_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !row_end |=> r_col == $past(r_col) + COL_W'(1))
        else $error("column counter did not advance");

    // counters hold while no transaction is taken
    a_counters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_col) && $stable(r_row))
        else $error("counters moved without a transaction");

    // the row counter only moves on a row end
    a_row_moves_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !row_end |=> $stable(r_row))
        else $error("row counter moved inside a row");
`endif

endmodule

[tb/sv/png_scanline_unfilter_tb.sv]
`timescale 1ns / 100ps

module png_scanline_unfilter_tb;
    import psu_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PIX  = 1320;
    localparam int PRINT_CAP   = 40;

    localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = APB_ADDR_W'(REG_SEL_WIDTH) << REG_SEL_BIT;
    localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = APB_ADDR_W'(REG_SEL_HEIGHT) << REG_SEL_BIT;

    // codes beyond paeth are reported as bad and passed through
    localparam logic [CODE_W-1:0] FILT_BAD_LO = 3'd5;
    localparam logic [CODE_W-1:0] FILT_BAD_MID = 3'd6;
    localparam logic [CODE_W-1:0] FILT_BAD_HI = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             bad;
        logic             row_end;
    } t_rebuilt;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    psu_in_if  pix_in ();
    psu_out_if pix_out ();

    png_scanline_unfilter #(
        .MAX_WIDTH (MAX_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the block state
    logic [PIX_W-1:0]    line_mem [MAX_W];
    bit                  line_written [MAX_W];
    logic [PIX_W-1:0]    left_px = '0;
    logic [PIX_W-1:0]    diag_px = '0;
    int unsigned         col_cnt = 0;
    int unsigned         row_cnt = 0;
    logic [WIDTH_W-1:0]  cfg_width = 13'd1;
    logic [HEIGHT_W-1:0] cfg_height = 16'd1;

    t_rebuilt pending_pixels[$];
    int       err_cnt = 0;
    int       sent_cnt = 0;
    int       cycle_cnt = 0;
    bit       idling_on = 1'b1;
    int       stall_left = 0;

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < PRINT_CAP) begin
            $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        end
        err_cnt++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // rebuild one pixel, advance the raster position, queue the result
    function automatic void predict_rebuilt(input logic [CODE_W-1:0] code,
                                            input logic [PIX_W-1:0] filt);
        logic [PIX_W-1:0] left_nb;
        logic [PIX_W-1:0] up_nb;
        logic [PIX_W-1:0] diag_nb;
        logic [PIX_W-1:0] res;
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      col;
        int               a;
        int               b;
        int               c;
        int               p;
        int               da;
        int               db;
        int               dc;
        int               pred;
        bit               last_col;
        w_eff = (cfg_width == '0) ? 1 :
                ((int'(cfg_width) > MAX_W) ? MAX_W : int'(cfg_width));
        h_eff = (cfg_height == '0) ? 1 : int'(cfg_height);
        col = col_cnt % MAX_W;
        left_nb = (col_cnt > 0) ? left_px : '0;
        up_nb = (row_cnt > 0) ? line_mem[col] : '0;
        diag_nb = (col_cnt > 0 && row_cnt > 0) ? diag_px : '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            a = int'(left_nb[k*CHAN_W +: CHAN_W]);
            b = int'(up_nb[k*CHAN_W +: CHAN_W]);
            c = int'(diag_nb[k*CHAN_W +: CHAN_W]);
            case (code)
                FILT_SUB: pred = a;
                FILT_UP: pred = b;
                FILT_AVG: pred = (a + b) / 2;
                FILT_PAETH: begin
                    p = a + b - c;
                    da = (p > a) ? p - a : a - p;
                    db = (p > b) ? p - b : b - p;
                    dc = (p > c) ? p - c : c - p;
                    if (da <= db && da <= dc) pred = a;
                    else if (db <= dc) pred = b;
                    else pred = c;
                end
                default: pred = 0;
            endcase
            res[k*CHAN_W +: CHAN_W] = filt[k*CHAN_W +: CHAN_W] + pred[CHAN_W-1:0];
        end
        line_mem[col] = res;
        line_written[col] = 1'b1;
        diag_px = up_nb;
        left_px = res;
        last_col = (col_cnt + 1 >= w_eff);
        if (last_col) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h_eff) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
        pending_pixels.push_back('{px: res, bad: (code > FILT_PAETH), row_end: last_col});
    endfunction

    // widest row that never reads a line store entry not yet written
    function automatic int unsigned widest_safe_width();
        int unsigned k;
        if (row_cnt == 0) return MAX_W;
        k = col_cnt;
        while (k < MAX_W && line_written[k]) k++;
        return (k == 0) ? 1 : k;
    endfunction

    // one pixel transaction, with an optional gap before it
    task automatic send_pixel(input logic [CODE_W-1:0] code, input logic [PIX_W-1:0] px);
        int gap;
        gap = idling_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            pix_in.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pix_in.valid = 1'b1;
        pix_in.filtered_red = px[0*CHAN_W +: CHAN_W];
        pix_in.filtered_green = px[1*CHAN_W +: CHAN_W];
        pix_in.filtered_blue = px[2*CHAN_W +: CHAN_W];
        pix_in.filtered_alpha = px[3*CHAN_W +: CHAN_W];
        pix_in.filter_code = code;
        do @(posedge i_clk); while (!pix_in.ready);
        predict_rebuilt(code, px);
        sent_cnt++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        @(negedge i_clk);
        pix_in.valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // width is trimmed where a wider row would read unwritten entries
    task automatic set_image(input int unsigned w, input int unsigned h);
        int unsigned w_eff;
        int unsigned safe;
        wait_idle();
        w_eff = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
        safe = widest_safe_width();
        if (w_eff > safe) w = safe;
        apb_write(WIDTH_ADDR, APB_DATA_W'(w[WIDTH_W-1:0]));
        cfg_width = w[WIDTH_W-1:0];
        apb_write(HEIGHT_ADDR, APB_DATA_W'(h[HEIGHT_W-1:0]));
        cfg_height = h[HEIGHT_W-1:0];
    endtask

    // random pixel, channels sometimes pinned to 0 or 255
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] px;
        px = $urandom;
        for (int k = 0; k < NUM_CHAN; k++) begin
            if ($urandom_range(0, 7) == 0) px[k*CHAN_W +: CHAN_W] = {CHAN_W{px[k*CHAN_W]}};
        end
        return px;
    endfunction

    function automatic logic [CODE_W-1:0] pick_row_code();
        if ($urandom_range(0, 99) < 93) return CODE_W'($urandom_range(FILT_NONE, FILT_PAETH));
        return CODE_W'($urandom_range(FILT_BAD_LO, FILT_BAD_HI));
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            pix_out.ready = 1'b0;
            stall_left--;
        end else begin
            pix_out.ready = 1'b1;
            if (idling_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_rebuilt want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing expected",
                                {pix_out.out_alpha, pix_out.out_blue,
                                 pix_out.out_green, pix_out.out_red}, '0);
            end else begin
                want = pending_pixels.pop_front();
                if (pix_out.out_red !== want.px[0*CHAN_W +: CHAN_W])
                    report_mismatch("out_red", 32'(pix_out.out_red),
                                    32'(want.px[0*CHAN_W +: CHAN_W]));
                if (pix_out.out_green !== want.px[1*CHAN_W +: CHAN_W])
                    report_mismatch("out_green", 32'(pix_out.out_green),
                                    32'(want.px[1*CHAN_W +: CHAN_W]));
                if (pix_out.out_blue !== want.px[2*CHAN_W +: CHAN_W])
                    report_mismatch("out_blue", 32'(pix_out.out_blue),
                                    32'(want.px[2*CHAN_W +: CHAN_W]));
                if (pix_out.out_alpha !== want.px[3*CHAN_W +: CHAN_W])
                    report_mismatch("out_alpha", 32'(pix_out.out_alpha),
                                    32'(want.px[3*CHAN_W +: CHAN_W]));
                if (pix_out.bad_filter !== want.bad)
                    report_mismatch("bad_filter", 32'(pix_out.bad_filter), 32'(want.bad));
                if (pix_out.row_end !== want.row_end)
                    report_mismatch("row_end", 32'(pix_out.row_end), 32'(want.row_end));
            end
        end
    end

    // reset values: one pixel per row, one row per image, no neighbours
    task automatic test_reset_geometry();
        send_pixel(FILT_SUB, 32'hFF80_01FE);
        send_pixel(FILT_PAETH, 32'h1234_5678);
    endtask

    // every filter code over a small image, sums wrapping past 255
    task automatic test_filter_codes();
        set_image(4, 3);
        send_pixel(FILT_NONE, 32'h0000_0000);
        send_pixel(FILT_SUB, 32'hFFFF_FFFF);
        send_pixel(FILT_AVG, 32'h80FF_017F);
        send_pixel(FILT_PAETH, 32'hFF00_FF00);
        send_pixel(FILT_UP, 32'hFFFF_FFFF);
        send_pixel(FILT_SUB, 32'h0102_0304);
        send_pixel(FILT_AVG, 32'hFFFF_FFFF);
        send_pixel(FILT_PAETH, 32'h7F80_00FF);
        send_pixel(FILT_BAD_LO, 32'hDEAD_BEEF);
        send_pixel(FILT_BAD_MID, 32'h00FF_00FF);
        send_pixel(FILT_BAD_HI, 32'hFFFF_0000);
        send_pixel(FILT_PAETH, 32'h0000_0000);
    endtask

    // out-of-range register values, widest row, and geometry lowered mid-image
    task automatic test_register_extremes();
        set_image(0, 0);
        send_pixel(FILT_SUB, 32'h0BAD_F00D);
        send_pixel(FILT_UP, 32'hFFFF_FFFF);
        set_image(8191, 65535);
        repeat (5) send_pixel(FILT_SUB, random_pixel());
        set_image(3, 65535);
        send_pixel(FILT_AVG, random_pixel());
        send_pixel(FILT_UP, random_pixel());
        send_pixel(FILT_PAETH, random_pixel());
        send_pixel(FILT_AVG, random_pixel());
        set_image(3, 1);
        send_pixel(FILT_PAETH, random_pixel());
        send_pixel(FILT_UP, random_pixel());
        send_pixel(FILT_SUB, random_pixel());
    endtask

    // random images: one code per row with occasional noise, geometry per phase
    task automatic test_random_images();
        int               start;
        int               burst;
        int unsigned      w;
        int unsigned      h;
        int               r;
        logic [CODE_W-1:0] row_code;
        logic [CODE_W-1:0] code;
        start = sent_cnt;
        row_code = FILT_NONE;
        while (sent_cnt - start < RANDOM_PIX) begin
            idling_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 60) w = $urandom_range(1, 8);
            else if (r < 88) w = $urandom_range(9, 48);
            else if (r < 95) w = $urandom_range(49, 300);
            else if (r < 97) w = MAX_W;
            else w = ($urandom_range(0, 1) != 0) ? 0 : 8191;
            r = $urandom_range(0, 99);
            if (r < 70) h = $urandom_range(1, 5);
            else if (r < 85) h = $urandom_range(6, 20);
            else if (r < 95) h = 65535;
            else h = 0;
            set_image(w, h);
            burst = $urandom_range(10, 60);
            repeat (burst) begin
                if (col_cnt == 0) row_code = pick_row_code();
                code = ($urandom_range(0, 19) == 0) ? CODE_W'($urandom_range(0, 7)) : row_code;
                send_pixel(code, random_pixel());
            end
        end
        idling_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_in.valid = 1'b0;
        pix_in.filtered_red = '0;
        pix_in.filtered_green = '0;
        pix_in.filtered_blue = '0;
        pix_in.filtered_alpha = '0;
        pix_in.filter_code = FILT_NONE;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_geometry();
        test_filter_codes();
        test_register_extremes();
        test_random_images();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
